@@ rtl/tpm_pkg.sv @@
// Shared types, codes and constants of the timer pool manager.
package tpm_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int TICK_W = 62;
  localparam int EXP_W = 63;

  localparam logic [EXP_W-1:0] UNUSED_MARK = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [EXP_W-1:0] INACTIVE_MARK = 63'h4000_0000_0000_0000;

  localparam logic [2:0] ACT_ALLOC = 3'd0;
  localparam logic [2:0] ACT_FREE = 3'd1;
  localparam logic [2:0] ACT_SET_ABS = 3'd2;
  localparam logic [2:0] ACT_SET_REL = 3'd3;
  localparam logic [2:0] ACT_CANCEL = 3'd4;
  localparam logic [2:0] ACT_TICK = 3'd5;
  localparam logic [2:0] ACT_FRESH = 3'd6;
  localparam logic [2:0] ACT_NONE = 3'd7;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_TOO_EARLY = 3'd1;
  localparam logic [2:0] ST_TOO_LATE = 3'd2;
  localparam logic [2:0] ST_NO_EVENT = 3'd3;
  localparam logic [2:0] ST_POOL_FULL = 3'd4;
  localparam logic [2:0] ST_INVALID = 3'd5;
  localparam logic [2:0] ST_EXPIRED = 3'd6;

  localparam logic [1:0] REG_MIN_REL = 2'd0;
  localparam logic [1:0] REG_MAX_REL = 2'd1;
  localparam logic [1:0] REG_IN_USE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SCAN_END
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic exec;
    logic scan_step;
    logic scan_fin;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_tick;
    logic out_free;
    logic scan_more;
    logic due;
    logic pend_vld;
  } sts_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot_index;
    logic old_event_present;
    logic [31:0] returned_event;
    logic [15:0] out_queue;
    logic [31:0] out_tag;
    logic [TICK_W-1:0] expiration;
    logic is_fresh;
    logic last;
  } res_t;

endpackage

@@ rtl/tpm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tpm_ctrl.sv @@
// Sequencing state machine of the timer pool manager.
module tpm_ctrl import tpm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_stall
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sts.in_valid) begin
          state_next = sts.in_tick ? S_SCAN_RD : S_READ;
        end
      end
      S_READ: state_next = S_EXEC;
      S_EXEC: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      S_SCAN_RD: state_next = sts.scan_more ? S_SCAN_EV : S_SCAN_END;
      S_SCAN_EV: begin
        if (!(sts.due && sts.pend_vld && !sts.out_free)) state_next = S_SCAN_RD;
      end
      S_SCAN_END: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.accept = sts.in_valid;
      end
      S_READ: cmd.rd = 1'b1;
      S_EXEC: cmd.exec = sts.out_free;
      S_SCAN_RD: ;
      S_SCAN_EV: cmd.scan_step = !(sts.due && sts.pend_vld && !sts.out_free);
      S_SCAN_END: cmd.scan_fin = sts.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/tpm_datapath.sv @@
// Slot storage, free list, checks and result register of the timer pool manager.
module tpm_datapath import tpm_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              in_valid,
  input  logic [2:0]        action,
  input  logic [5:0]        timer_index,
  input  logic [TICK_W-1:0] tick_value,
  input  logic              event_present,
  input  logic [31:0]       event_handle,
  input  logic [15:0]       dest_queue,
  input  logic [31:0]       owner_tag,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output res_t              res,
  output logic              out_valid,
  input  logic              out_stall
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(NUM_SLOTS);

  logic [2:0]        a_act;
  logic [5:0]        a_idx;
  logic [TICK_W-1:0] a_tv;
  logic              a_newp;
  logic [31:0]       a_newev;
  logic [15:0]       a_q;
  logic [31:0]       a_tag;

  logic [31:0] min_rel, max_rel;
  logic [6:0]  in_use;

  logic [TICK_W-1:0] now_tick;
  logic [CW-1:0] free_head, alloc_cnt, high_water, scan_i;
  logic [NUM_SLOTS-1:0] has_ev, exp_vld, lnk_vld;
  logic [EXP_W-1:0] lo, hi, rsum;

  logic p_vld;
  res_t p_res;
  logic o_vld;
  res_t o_res;

  logic tick_mode;
  logic [IW-1:0] slot, sc, asl, rs;
  logic [EXP_W-1:0] exp_q, e;
  logic [31:0] ev_q;
  logic [47:0] qt_q;
  logic [CW-1:0] lnk_q, lk;
  logic due, out_free;

  assign tick_mode = (a_act == ACT_TICK);
  assign slot = a_idx[IW-1:0];
  assign sc = scan_i[IW-1:0];
  assign asl = free_head[IW-1:0];
  assign rs = tick_mode ? sc : slot;
  assign e = exp_vld[rs] ? exp_q : UNUSED_MARK;
  assign lk = lnk_vld[asl] ? lnk_q : CW'(asl) + CW'(1);
  assign due = (e <= {1'b0, a_tv}) && has_ev[sc];
  assign out_free = !o_vld || !out_stall;

  assign sts.in_valid = in_valid;
  assign sts.in_tick = (action == ACT_TICK);
  assign sts.out_free = out_free;
  assign sts.scan_more = scan_i < high_water;
  assign sts.due = due;
  assign sts.pend_vld = p_vld;

  // execute one command
  res_t ex_res;
  logic ex_exp_we, ex_free, ex_take, ex_set_ev, ex_alloc;
  logic [EXP_W-1:0] ex_exp_wd;
  logic [6:0] lim;
  logic early, late, bad_idx;
  logic [EXP_W-1:0] abs_tck;

  always_comb begin
    ex_res = '0;
    ex_res.last = 1'b1;
    ex_exp_we = 1'b0;
    ex_exp_wd = INACTIVE_MARK;
    ex_free = 1'b0;
    ex_take = 1'b0;
    ex_set_ev = 1'b0;
    ex_alloc = 1'b0;
    lim = (in_use > 7'(NUM_SLOTS)) ? 7'(NUM_SLOTS) : in_use;
    bad_idx = ({2'b00, a_idx} >= 8'(high_water));
    if (a_act == ACT_SET_ABS) begin
      abs_tck = {1'b0, a_tv};
      early = abs_tck < lo;
      late = abs_tck > hi;
    end else begin
      abs_tck = rsum;
      early = a_tv < {30'd0, min_rel};
      late = (a_tv > {30'd0, max_rel}) || rsum[EXP_W-1];
    end
    priority if (a_act == ACT_ALLOC) begin
      if ((7'(alloc_cnt) >= lim) || (free_head >= SLOTS_C)) begin
        ex_res.status = ST_POOL_FULL;
      end else begin
        ex_alloc = 1'b1;
        ex_exp_we = 1'b1;
        ex_res.slot_index = 6'(asl);
      end
    end else if (a_act == ACT_NONE || bad_idx) begin
      ex_res.status = ST_INVALID;
    end else if (a_act == ACT_FRESH) begin
      ex_res.is_fresh = (a_tv == e[TICK_W-1:0]);
    end else if (e == UNUSED_MARK) begin
      ex_res.status = ST_INVALID;
    end else if (a_act == ACT_FREE) begin
      ex_take = 1'b1;
      ex_free = 1'b1;
      ex_res.old_event_present = has_ev[slot];
      ex_res.returned_event = has_ev[slot] ? ev_q : 32'd0;
    end else if (a_act == ACT_CANCEL) begin
      ex_take = 1'b1;
      ex_exp_we = 1'b1;
      ex_res.status = has_ev[slot] ? ST_OK : ST_NO_EVENT;
      ex_res.old_event_present = has_ev[slot];
      ex_res.returned_event = has_ev[slot] ? ev_q : 32'd0;
    end else begin
      ex_exp_wd = abs_tck;
      priority if (early) begin
        ex_res.status = ST_TOO_EARLY;
      end else if (late) begin
        ex_res.status = ST_TOO_LATE;
      end else if (a_newp) begin
        ex_take = 1'b1;
        ex_set_ev = 1'b1;
        ex_exp_we = 1'b1;
        ex_res.old_event_present = has_ev[slot];
        ex_res.returned_event = has_ev[slot] ? ev_q : 32'd0;
      end else if (has_ev[slot]) begin
        ex_exp_we = 1'b1;
      end else begin
        ex_res.status = ST_NO_EVENT;
      end
    end
  end

  res_t sc_res;
  always_comb begin
    sc_res = '0;
    sc_res.status = ST_EXPIRED;
    sc_res.slot_index = 6'(sc);
    sc_res.old_event_present = 1'b1;
    sc_res.returned_event = ev_q;
    sc_res.out_queue = qt_q[47:32];
    sc_res.out_tag = qt_q[31:0];
    sc_res.expiration = e[TICK_W-1:0];
  end

  res_t fin_res;
  always_comb begin
    fin_res = p_vld ? p_res : '0;
    fin_res.last = 1'b1;
  end

  logic exp_we, ev_we, qt_we, lnk_we;
  logic [IW-1:0] exp_wa;
  logic [EXP_W-1:0] exp_wd;

  assign exp_we = (cmd.exec && ex_exp_we) || (cmd.scan_step && due);
  assign exp_wa = tick_mode ? sc : (ex_alloc ? asl : slot);
  assign exp_wd = tick_mode ? (e | INACTIVE_MARK) : ex_exp_wd;
  assign ev_we = cmd.exec && ex_set_ev;
  assign qt_we = cmd.exec && ex_alloc;
  assign lnk_we = cmd.exec && ex_free;

  tpm_ram #(.WIDTH(EXP_W), .DEPTH(NUM_SLOTS)) u_exp_ram (
    .clk(clk), .we(exp_we), .waddr(exp_wa), .wdata(exp_wd), .raddr(rs), .rdata(exp_q)
  );
  tpm_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_ev_ram (
    .clk(clk), .we(ev_we), .waddr(slot), .wdata(a_newev), .raddr(rs), .rdata(ev_q)
  );
  tpm_ram #(.WIDTH(48), .DEPTH(NUM_SLOTS)) u_qt_ram (
    .clk(clk), .we(qt_we), .waddr(asl), .wdata({a_q, a_tag}), .raddr(sc), .rdata(qt_q)
  );
  tpm_ram #(.WIDTH(CW), .DEPTH(NUM_SLOTS)) u_lnk_ram (
    .clk(clk), .we(lnk_we), .waddr(slot), .wdata(free_head), .raddr(asl), .rdata(lnk_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      a_act <= action;
      a_idx <= timer_index;
      a_tv <= tick_value;
      a_newp <= event_present;
      a_newev <= event_handle;
      a_q <= dest_queue;
      a_tag <= owner_tag;
    end
    if (cmd.rd) begin
      lo <= {1'b0, now_tick} + EXP_W'(min_rel);
      hi <= {1'b0, now_tick} + EXP_W'(max_rel);
      rsum <= {1'b0, now_tick} + {1'b0, a_tv};
    end
    if (cmd.scan_step && due) begin
      p_res <= sc_res;
    end
    if (cmd.exec) begin
      o_res <= ex_res;
    end else if (cmd.scan_step && due && p_vld) begin
      o_res <= p_res;
    end else if (cmd.scan_fin) begin
      o_res <= fin_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_rel <= 32'd0;
      max_rel <= 32'hFFFF_FFFF;
      in_use <= 7'd64;
      now_tick <= '0;
      free_head <= '0;
      alloc_cnt <= '0;
      high_water <= '0;
      scan_i <= '0;
      has_ev <= '0;
      exp_vld <= '0;
      lnk_vld <= '0;
      p_vld <= 1'b0;
      o_vld <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_REL: min_rel <= cfg_data;
          REG_MAX_REL: max_rel <= cfg_data;
          REG_IN_USE: in_use <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        scan_i <= '0;
        p_vld <= 1'b0;
        if (action == ACT_TICK) now_tick <= tick_value;
      end
      if (cmd.scan_step) begin
        scan_i <= scan_i + CW'(1);
        if (due) begin
          p_vld <= 1'b1;
          has_ev[sc] <= 1'b0;
        end
      end
      if (cmd.scan_fin) p_vld <= 1'b0;
      if (exp_we) exp_vld[exp_wa] <= 1'b1;
      if (cmd.exec) begin
        if (ex_take) has_ev[slot] <= ex_set_ev;
        if (ex_alloc) begin
          has_ev[asl] <= 1'b0;
          free_head <= lk;
          alloc_cnt <= alloc_cnt + CW'(1);
          if (alloc_cnt + CW'(1) > high_water) high_water <= alloc_cnt + CW'(1);
        end
        if (ex_free) begin
          exp_vld[slot] <= 1'b0;
          lnk_vld[slot] <= 1'b1;
          free_head <= CW'(slot);
          if (alloc_cnt != '0) alloc_cnt <= alloc_cnt - CW'(1);
        end
      end
      if (cmd.exec || (cmd.scan_step && due && p_vld) || cmd.scan_fin) begin
        o_vld <= 1'b1;
      end else if (!out_stall) begin
        o_vld <= 1'b0;
      end
    end
  end

  assign res = o_res;
  assign out_valid = o_vld;

endmodule

@@ rtl/timer_pool_manager_unit.sv @@
// Top level of the timer pool manager.
// A command (alloc, free, set, cancel, fresh check) runs in these steps from
// acceptance: taking the beat, the registered read of the slot memories, and
// the check and write back, which waits for the result register to drain. A
// tick takes the beat, then scans each slot up to the high-water mark with a
// registered slot read and its evaluation, then does a closing bound check and
// gives the final result, waiting whenever the result register has not drained.
// A finished result waits in an output register while the next beat is taken.
module timer_pool_manager_unit import tpm_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        action,
  input  logic [5:0]        timer_index,
  input  logic [TICK_W-1:0] tick_value,
  input  logic              event_present,
  input  logic [31:0]       event_handle,
  input  logic [15:0]       dest_queue,
  input  logic [31:0]       owner_tag,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [5:0]        slot_index,
  output logic              old_event_present,
  output logic [31:0]       returned_event,
  output logic [15:0]       out_queue,
  output logic [31:0]       out_tag,
  output logic [TICK_W-1:0] expiration,
  output logic              is_fresh,
  output logic              last
);

  cmd_t cmd;
  sts_t sts;
  res_t res;

  tpm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .sts(sts), .cmd(cmd), .in_stall(in_stall)
  );

  tpm_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .in_valid(in_valid),
    .action(action), .timer_index(timer_index), .tick_value(tick_value),
    .event_present(event_present), .event_handle(event_handle),
    .dest_queue(dest_queue), .owner_tag(owner_tag),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .res(res), .out_valid(out_valid), .out_stall(out_stall)
  );

  assign status = res.status;
  assign slot_index = res.slot_index;
  assign old_event_present = res.old_event_present;
  assign returned_event = res.returned_event;
  assign out_queue = res.out_queue;
  assign out_tag = res.out_tag;
  assign expiration = res.expiration;
  assign is_fresh = res.is_fresh;
  assign last = res.last;

endmodule

@@ rtl/tpm_checker.sv @@
// Port-level checker of the timer pool manager and its bind.
module tpm_checker import tpm_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status,
  input logic [5:0] slot_index,
  input logic       old_event_present,
  input logic       is_fresh
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_expired_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EXPIRED |-> old_event_present)
    else $error("expiry without event");

  a_fresh_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_fresh |-> status == ST_OK && !old_event_present)
    else $error("fresh flag on a non-ok result");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_POOL_FULL |-> slot_index == 6'd0 && !old_event_present)
    else $error("pool full result carries a slot");

endmodule

bind timer_pool_manager_unit tpm_checker u_tpm_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .status(status), .slot_index(slot_index),
  .old_event_present(old_event_present), .is_fresh(is_fresh)
);
